// ===== hw/rtl/weno3_pkg.sv =====
package weno3_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 24;
    localparam int NORM_BITS      = 30;
    localparam int EPS_WIDTH      = 16;
    localparam logic [EPS_WIDTH-1:0] EPS_RESET = 16'd17;

endpackage

// ===== hw/rtl/weno3_if.sv =====
interface weno3_in_if #(
    parameter int DATA_WIDTH = weno3_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] flux_left;
    logic signed [DATA_WIDTH-1:0] flux_center;
    logic signed [DATA_WIDTH-1:0] flux_right;

    modport source (output valid, flux_left, flux_center, flux_right, input ready);
    modport sink (input valid, flux_left, flux_center, flux_right, output ready);
endinterface

interface weno3_out_if #(
    parameter int DATA_WIDTH = weno3_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] flux_hat;
    logic                         saturated;

    modport source (output valid, flux_hat, saturated, input ready);
    modport sink (input valid, flux_hat, saturated, output ready);
endinterface

// ===== hw/rtl/weno3_stencil_reconstruction_core.sv =====
// Third-order WENO reconstruction of one interface value per stencil.
// The input channel i_in carries the left, centre and right stencil values;
// a transfer happens on a clock edge where valid and ready are both high.
// The output channel o_out returns one reconstructed value per input
// transfer, in order, with a flag that is set when the value was clipped.
// The user must write the epsilon register through i_cfg_we and i_cfg_wdata
// only while the block is idle; the block itself does not enforce this.
// The pipeline has eleven stages of squaring, normalisation, weight products
// and accumulation, one restoring divider stage per quotient bit (DATA_WIDTH
// + 3) and an output register with saturation. A new stencil is taken in
// every cycle unless a stall at o_out holds i_in.ready low.
// Every stage holds its item while the stage after it is full and stalled,
// so a stall at o_out fills the empty stages first and then holds i_in.ready
// low; nothing is lost or repeated.
// A synchronous reset empties the pipeline and sets epsilon to 17.
module weno3_stencil_reconstruction_core #(
    parameter int DATA_WIDTH = weno3_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = weno3_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [weno3_pkg::EPS_WIDTH-1:0]    i_cfg_wdata,
    weno3_in_if.sink                           i_in,
    weno3_out_if.source                        o_out
);
    localparam int DW   = DATA_WIDTH;
    localparam int NB   = weno3_pkg::NORM_BITS;
    localparam int EW   = weno3_pkg::EPS_WIDTH;
    localparam int SQW  = 2 * DW + 2;
    localparam int SW   = ((SQW > EW + FRAC_BITS) ? SQW : EW + FRAC_BITS) + 1;
    localparam int LW   = $clog2(SW + 1);
    localparam int SUMW = 2 * NB + 2;
    localparam int DENW = 2 * NB + 3;
    localparam int PPW  = NB + DW + 5;
    localparam int NW   = 2 * NB + DW + 6;
    localparam int QW   = DW + 3;
    localparam int NDIV = 11;
    localparam int NS   = NDIV + QW + 1;

    logic [EW-1:0] r_eps;
    logic [NS-1:0] r_v;
    logic [NS-1:0] en;
    logic [NS-1:0] vin;
    logic [NS-1:0] ld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= weno3_pkg::EPS_RESET;
            r_v   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_eps <= i_cfg_wdata;
            end
            r_v <= (r_v & ~en) | (vin & en);
        end
    end

    always_comb begin
        en[NS-1] = !r_v[NS-1] || o_out.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign vin        = {r_v[NS-2:0], i_in.valid};
    assign ld         = vin & en;
    assign i_in.ready = en[0];

    logic signed [DW:0]   r0_d0, r0_d1, r0_m1;
    logic signed [DW+2:0] r0_m0;
    logic [SQW-1:0]       r1_sq0, r1_sq1;
    logic signed [DW:0]   r1_m1;
    logic signed [DW+2:0] r1_m0;
    logic [SW-1:0]        r2_s0, r2_s1;
    logic signed [DW:0]   r2_m1;
    logic signed [DW+2:0] r2_m0;
    logic [SW-1:0]        r3_s0, r3_s1;
    logic [LW-1:0]        r3_sh;
    logic signed [DW:0]   r3_m1;
    logic signed [DW+2:0] r3_m0;
    logic [NB-1:0]        r4_n0, r4_n1;
    logic signed [DW:0]   r4_m1;
    logic signed [DW+2:0] r4_m0;
    logic [2*NB-1:0]      r5_a;
    logic [2*NB:0]        r5_b;
    logic signed [DW:0]   r5_m1;
    logic signed [DW+2:0] r5_m0;
    logic signed [PPW-1:0] r6_pa_lo, r6_pa_hi, r6_pb_lo, r6_pb_hi;
    logic [SUMW-1:0]      r6_sum, r7_sum, r8_sum, r9_sum;
    logic signed [NW-1:0] r7_pa, r7_pb, r8_n;
    logic [NW-1:0]        r9_mag, r10_num;
    logic                 r9_neg, r10_neg;
    logic [DENW-1:0]      r10_den;

    logic [SW-1:0]  s_or;
    logic [LW-1:0]  len;
    logic [SW-1:0]  sh0, sh1;
    logic [2*NB-1:0] sq_n0, sq_n1;

    always_comb begin
        s_or = r2_s0 | r2_s1;
        len  = '0;
        for (int i = 0; i < SW; i++) begin
            if (s_or[i]) begin
                len = LW'(i + 1);
            end
        end
    end

    assign sh0   = r3_s0 >> r3_sh;
    assign sh1   = r3_s1 >> r3_sh;
    assign sq_n0 = r4_n0 * r4_n0;
    assign sq_n1 = r4_n1 * r4_n1;

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r0_d0 <= (DW+1)'(i_in.flux_center) - (DW+1)'(i_in.flux_left);
            r0_d1 <= (DW+1)'(i_in.flux_right) - (DW+1)'(i_in.flux_center);
            r0_m0 <= ((DW+3)'(i_in.flux_center) <<< 1) + (DW+3)'(i_in.flux_center)
                     - (DW+3)'(i_in.flux_left);
            r0_m1 <= (DW+1)'(i_in.flux_center) + (DW+1)'(i_in.flux_right);
        end
        if (ld[1]) begin
            r1_sq0 <= r0_d0 * r0_d0;
            r1_sq1 <= r0_d1 * r0_d1;
            r1_m0  <= r0_m0;
            r1_m1  <= r0_m1;
        end
        if (ld[2]) begin
            r2_s0 <= SW'(r1_sq0) + SW'({r_eps, {FRAC_BITS{1'b0}}});
            r2_s1 <= SW'(r1_sq1) + SW'({r_eps, {FRAC_BITS{1'b0}}});
            r2_m0 <= r1_m0;
            r2_m1 <= r1_m1;
        end
        if (ld[3]) begin
            r3_s0 <= r2_s0;
            r3_s1 <= r2_s1;
            r3_sh <= (len > LW'(NB)) ? len - LW'(NB) : '0;
            r3_m0 <= r2_m0;
            r3_m1 <= r2_m1;
        end
        if (ld[4]) begin
            r4_n0 <= sh0[NB-1:0];
            r4_n1 <= sh1[NB-1:0];
            r4_m0 <= r3_m0;
            r4_m1 <= r3_m1;
        end
        if (ld[5]) begin
            if (r4_n0 == '0 && r4_n1 == '0) begin
                r5_a <= (2*NB)'(1);
                r5_b <= (2*NB+1)'(2);
            end else begin
                r5_a <= sq_n1;
                r5_b <= {sq_n0, 1'b0};
            end
            r5_m0 <= r4_m0;
            r5_m1 <= r4_m1;
        end
        if (ld[6]) begin
            r6_pa_lo <= $signed({1'b0, r5_a[NB-1:0]}) * r5_m0;
            r6_pa_hi <= $signed({1'b0, r5_a[2*NB-1:NB]}) * r5_m0;
            r6_pb_lo <= $signed({1'b0, r5_b[NB-1:0]}) * r5_m1;
            r6_pb_hi <= $signed({1'b0, r5_b[2*NB:NB]}) * r5_m1;
            r6_sum   <= SUMW'(r5_a) + SUMW'(r5_b);
        end
        if (ld[7]) begin
            r7_pa  <= NW'(r6_pa_lo) + (NW'(r6_pa_hi) <<< NB);
            r7_pb  <= NW'(r6_pb_lo) + (NW'(r6_pb_hi) <<< NB);
            r7_sum <= r6_sum;
        end
        if (ld[8]) begin
            r8_n   <= r7_pa + r7_pb;
            r8_sum <= r7_sum;
        end
        if (ld[9]) begin
            r9_neg <= r8_n[NW-1];
            r9_mag <= r8_n[NW-1] ? $unsigned(-r8_n) : $unsigned(r8_n);
            r9_sum <= r8_sum;
        end
        if (ld[10]) begin
            r10_num <= r9_mag + NW'(r9_sum);
            r10_den <= {r9_sum, 1'b0};
            r10_neg <= r9_neg;
        end
    end

    logic [DENW-1:0] r_rem [QW];
    logic [DENW-1:0] r_den [QW];
    logic [QW-1:0]   r_lo  [QW];
    logic [QW-1:0]   r_q   [QW];
    logic            r_neg [QW];

    for (genvar j = 0; j < QW; j++) begin : g_div
        logic [DENW-1:0] rem_in, den_in;
        logic [QW-1:0]   lo_in, q_in;
        logic            neg_in;
        logic [DENW:0]   t, diff;
        logic            ge;

        if (j == 0) begin : g_first
            assign rem_in = r10_num[NW-1:QW];
            assign den_in = r10_den;
            assign lo_in  = r10_num[QW-1:0];
            assign q_in   = '0;
            assign neg_in = r10_neg;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign den_in = r_den[j-1];
            assign lo_in  = r_lo[j-1];
            assign q_in   = r_q[j-1];
            assign neg_in = r_neg[j-1];
        end

        assign t    = {rem_in, lo_in[QW-1-j]};
        assign ge   = t >= {1'b0, den_in};
        assign diff = t - {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (ld[NDIV+j]) begin
                r_rem[j] <= ge ? diff[DENW-1:0] : t[DENW-1:0];
                r_den[j] <= den_in;
                r_lo[j]  <= lo_in;
                r_q[j]   <= {q_in[QW-2:0], ge};
                r_neg[j] <= neg_in;
            end
        end
    end

    logic [QW-1:0]        lim_pos, lim_neg, q_fin;
    logic                 sat;
    logic signed [DW-1:0] res;
    logic signed [DW-1:0] r_hat;
    logic                 r_sat;

    assign lim_pos = {{(QW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    assign lim_neg = QW'(1) << (DW - 1);
    assign q_fin   = r_q[QW-1];

    always_comb begin
        if (r_neg[QW-1]) begin
            sat = q_fin > lim_neg;
            res = sat ? -$signed(lim_neg[DW-1:0]) : -$signed(q_fin[DW-1:0]);
        end else begin
            sat = q_fin > lim_pos;
            res = sat ? $signed(lim_pos[DW-1:0]) : $signed(q_fin[DW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[NS-1]) begin
            r_hat <= res;
            r_sat <= sat;
        end
    end

    assign o_out.valid     = r_v[NS-1];
    assign o_out.flux_hat  = r_hat;
    assign o_out.saturated = r_sat;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int DW = weno3_pkg::DATA_WIDTH_DEF;
    localparam int FB = weno3_pkg::FRAC_BITS_DEF;
    localparam int EW = weno3_pkg::EPS_WIDTH;
    localparam int LATENCY = DW + 15;

    typedef struct packed {
        logic signed [DW-1:0] left;
        logic signed [DW-1:0] centre;
        logic signed [DW-1:0] right;
    } t_stencil;

    typedef struct packed {
        logic signed [DW-1:0] hat;
        logic                 sat;
    } t_recon;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [EW-1:0] i_cfg_wdata;

    weno3_in_if  #(.DATA_WIDTH(DW)) in_if ();
    weno3_out_if #(.DATA_WIDTH(DW)) out_if ();

    weno3_stencil_reconstruction_core #(
        .DATA_WIDTH(DW),
        .FRAC_BITS (FB)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    t_stencil      stencils[$];
    t_recon        expected_recon[$];
    logic [EW-1:0] eps_model;
    int            mismatches;
    bit            calm;
    bit            hold_go;
    bit            hold_done;
    int            hold_cnt;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic t_recon predict_recon(t_stencil s, logic [EW-1:0] eps);
        logic signed [33:0]  d0, d1;
        logic [33:0]         a0, a1;
        logic [66:0]         s0, s1, both;
        int                  len, sh;
        logic [63:0]         n0, n1, wa, wb, tot;
        logic signed [35:0]  t0, t1;
        logic signed [127:0] num;
        logic [127:0]        absn, q;
        logic                neg;
        t_recon              r;
        d0 = s.centre;
        d0 = d0 - s.left;
        d1 = s.right;
        d1 = d1 - s.centre;
        a0 = d0 < 0 ? -d0 : d0;
        a1 = d1 < 0 ? -d1 : d1;
        s0 = 67'(a0) * 67'(a0) + (67'(eps) << FB);
        s1 = 67'(a1) * 67'(a1) + (67'(eps) << FB);
        both = s0 | s1;
        len = 0;
        for (int i = 0; i < 67; i++) begin
            if (both[i]) len = i + 1;
        end
        sh = len > weno3_pkg::NORM_BITS ? len - weno3_pkg::NORM_BITS : 0;
        n0 = 64'(s0 >> sh);
        n1 = 64'(s1 >> sh);
        wa = n1 * n1;
        wb = 64'd2 * n0 * n0;
        if (wa + wb == 64'd0) begin
            wa = 64'd1;
            wb = 64'd2;
        end
        tot = wa + wb;
        t0 = s.centre;
        t0 = 3 * t0 - s.left;
        t1 = s.centre;
        t1 = t1 + s.right;
        num = $signed(128'(wa)) * t0 + $signed(128'(wb)) * t1;
        neg = num < 0;
        absn = neg ? -num : num;
        q = (absn + 128'(tot)) / (128'(tot) * 2);
        r.sat = 1'b0;
        if (!neg) begin
            if (q > 128'(32'h7fffffff)) begin
                r.hat = 32'h7fffffff;
                r.sat = 1'b1;
            end else begin
                r.hat = q[DW-1:0];
            end
        end else begin
            if (q > 128'(32'h80000000)) begin
                r.hat = 32'h80000000;
                r.sat = 1'b1;
            end else begin
                r.hat = -q[DW-1:0];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [DW-1:0] got, logic [DW-1:0] want);
        $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_stencil s;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                s.left = in_if.flux_left;
                s.centre = in_if.flux_center;
                s.right = in_if.flux_right;
                expected_recon.push_back(predict_recon(s, eps_model));
            end
            if (!in_if.valid || in_if.ready) begin
                if (stencils.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
                    s = stencils.pop_front();
                    in_if.valid       <= 1'b1;
                    in_if.flux_left   <= s.left;
                    in_if.flux_center <= s.centre;
                    in_if.flux_right  <= s.right;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_go && !hold_done) begin
            hold_cnt  <= 300;
            hold_done <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    always @(posedge i_clk) begin
        if (hold_cnt > 0 || (hold_go && !hold_done)) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= calm || $urandom_range(99) >= 20;
        end
    end

    always @(posedge i_clk) begin
        t_recon want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_recon.size() == 0) begin
                report_mismatch("unexpected transfer", out_if.flux_hat, '0);
            end else begin
                want = expected_recon.pop_front();
                if (out_if.flux_hat !== want.hat) begin
                    report_mismatch("flux_hat", out_if.flux_hat, want.hat);
                end
                if (out_if.saturated !== want.sat) begin
                    report_mismatch("saturated", DW'(out_if.saturated), DW'(want.sat));
                end
            end
        end
    end

    task automatic add_stencil(logic [DW-1:0] l, logic [DW-1:0] c, logic [DW-1:0] r);
        t_stencil s;
        s.left = l;
        s.centre = c;
        s.right = r;
        stencils.push_back(s);
    endtask

    task automatic add_random(int count);
        logic [DW-1:0] base;
        int            spread;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(3))
                0: add_stencil($urandom, $urandom, $urandom);
                1: begin
                    base = $urandom;
                    spread = 1 << $urandom_range(30);
                    add_stencil(base + $urandom_range(spread), base,
                                base - $urandom_range(spread));
                end
                2: begin
                    base = $urandom >> $urandom_range(31);
                    add_stencil(base, base + ($urandom >> $urandom_range(31)),
                                base - ($urandom >> $urandom_range(31)));
                end
                default: begin
                    add_stencil($urandom_range(1) ? 32'h7fffffff : 32'h80000000,
                                $urandom, $urandom_range(1) ? 32'h7fffffff : $urandom);
                end
            endcase
        end
    endtask

    task automatic drain();
        while (stencils.size() != 0 || expected_recon.size() != 0 || in_if.valid) begin
            @(posedge i_clk);
        end
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_eps(logic [EW-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        eps_model = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        #2ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        in_if.valid       = 1'b0;
        in_if.flux_left   = '0;
        in_if.flux_center = '0;
        in_if.flux_right  = '0;
        out_if.ready      = 1'b0;
        eps_model         = weno3_pkg::EPS_RESET;
        mismatches        = 0;
        calm              = 1'b0;
        hold_go           = 1'b0;
        hold_done         = 1'b0;
        hold_cnt          = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_stencil(32'h0, 32'h0, 32'h0);
        add_stencil(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        add_stencil(32'h80000000, 32'h80000000, 32'h80000000);
        add_stencil(32'h80000000, 32'h7fffffff, 32'h80000000);
        add_stencil(32'h7fffffff, 32'h80000000, 32'h7fffffff);
        add_stencil(32'h80000000, 32'h7fffffff, 32'h7fffffff);
        add_stencil(32'h7fffffff, 32'h80000000, 32'h80000000);
        add_stencil(32'h01000000, 32'h02000000, 32'h03000000);
        add_stencil(32'hffffffff, 32'h00000001, 32'hffffffff);
        add_stencil(32'h00000000, 32'h00000000, 32'h7fffffff);
        add_stencil(32'h00000000, 32'h01000000, 32'h00000000);
        add_stencil(32'hffffffff, 32'hffffffff, 32'hffffffff);
        drain();

        write_eps(16'd0);
        add_stencil(32'h0, 32'h0, 32'h0);
        add_stencil(32'h12345678, 32'h12345678, 32'h12345678);
        add_stencil(32'h80000000, 32'h80000000, 32'h80000000);
        add_stencil(32'h00000001, 32'h00000001, 32'h00000002);
        add_stencil(32'h00000003, 32'h00000001, 32'h00000001);
        add_random(60);
        drain();

        write_eps(16'hffff);
        hold_go <= 1'b1;
        add_random(120);
        drain();

        write_eps(16'd1);
        calm = 1'b1;
        add_random(100);
        drain();
        calm = 1'b0;

        write_eps(16'd17);
        add_random(50);
        drain();

        write_eps(16'($urandom));
        add_random(70);
        drain();

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/weno3_pkg.sv
hw/rtl/weno3_if.sv
hw/rtl/weno3_stencil_reconstruction_core.sv
dv/tb_top.sv
